/* rtl/nearest_match_by_dot_product_unit_assert.svh */
// Assertion macros shared by the nearest match unit
`ifndef NEAREST_MATCH_BY_DOT_PRODUCT_UNIT_ASSERT_SVH
`define NEAREST_MATCH_BY_DOT_PRODUCT_UNIT_ASSERT_SVH

// property checked every cycle outside reset
`define NMDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// trigger in one cycle, property in the next
`define NMDP_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/nmdp_pkg.sv */
// Types and constants of the nearest match unit
package nmdp_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_DIM_DEF     = 256;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 40;
  localparam int THR_W    = 32;
  localparam int DIM_W    = 9;
  localparam int ENTRY_W  = 6;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [THR_W-1:0] THR_RESET = 32'h2000_0000;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DIM       = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]      best_entry;
    logic signed [ACC_W-1:0] similarity;
    logic                    known;
  } out_beat_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic keep_old;
  } sweep_ctl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } mac_stat_t;

endpackage

/* rtl/nmdp_ram.sv */
// Generic single write port, single read port RAM with registered read
module nmdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nmdp_mac.sv */
// Shared multiply, saturating accumulate and running maximum unit
module nmdp_mac #(
  parameter int MAX_ENTRIES = nmdp_pkg::MAX_ENTRIES_DEF,
  parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nmdp_pkg::sweep_ctl_t                ctl,
  input  logic [IDX_W-1:0]                    idx,
  input  logic signed [nmdp_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [nmdp_pkg::SAMPLE_W-1:0] gal_data,
  input  logic signed [nmdp_pkg::ACC_W-1:0]    acc_data,
  output logic                                acc_we,
  output logic [IDX_W-1:0]                    acc_waddr,
  output logic signed [nmdp_pkg::ACC_W-1:0]    acc_wdata,
  output logic signed [nmdp_pkg::ACC_W-1:0]    best_val,
  output logic [IDX_W-1:0]                    best_idx,
  output nmdp_pkg::mac_stat_t                 stat
);

  import nmdp_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int SUM_W  = ACC_W + 1;

  // stage C: product and old sum
  logic                       vc_r, vc_nxt;
  logic [IDX_W-1:0]           ec_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    accold_r;
  // stage D: new sum into the maximum
  logic                       vd_r, vd_nxt;
  logic [IDX_W-1:0]           ed_r;
  logic signed [ACC_W-1:0]    sum_r;
  logic signed [ACC_W-1:0]    best_r, best_nxt;
  logic [IDX_W-1:0]           bidx_r, bidx_nxt;
  logic                       found_r, found_nxt;

  logic signed [SUM_W-1:0]    sum_wide;
  logic signed [ACC_W-1:0]    sum_sat;

  always_comb begin
    sum_wide = SUM_W'(accold_r) + SUM_W'(prod_r);
    if (sum_wide[SUM_W-1] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  always_comb begin
    vc_nxt    = ctl.valid;
    vd_nxt    = vc_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    found_nxt = found_r;
    if (ctl.clear) begin
      best_nxt  = '0;
      bidx_nxt  = '0;
      found_nxt = 1'b0;
    end else if (vd_r && (!found_r || (sum_r > best_r))) begin
      best_nxt  = sum_r;
      bidx_nxt  = ed_r;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r    <= 1'b0;
      vd_r    <= 1'b0;
      found_r <= 1'b0;
      best_r  <= '0;
      bidx_r  <= '0;
    end else begin
      vc_r    <= vc_nxt;
      vd_r    <= vd_nxt;
      found_r <= found_nxt;
      best_r  <= best_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ec_r     <= idx;
    prod_r   <= gal_data * sample;
    accold_r <= ctl.keep_old ? acc_data : '0;
    ed_r     <= ec_r;
    sum_r    <= sum_sat;
  end

  assign acc_we     = vc_r;
  assign acc_waddr  = ec_r;
  assign acc_wdata  = sum_sat;
  assign best_val   = best_r;
  assign best_idx   = bidx_r;
  assign stat.busy  = vc_r | vd_r;
  assign stat.found = found_r;

endmodule

/* rtl/nearest_match_by_dot_product_unit.sv */
// Top level of the nearest match unit: sequencer, registers and memories
//
// Usage
//   Input channel (in_valid / in_stall / in_data): op 0 appends one element
//   to the gallery entry being built, op 1 is one element of a query vector.
//   Result channel (out_valid / out_stall / out_data): one beat after the
//   last element of each query vector, with best entry, similarity, known.
//   Configuration through the cfg_ APB port: threshold at 0x0, feature_dim
//   at 0x4; write only while the unit is idle.
//   A load beat leaves the unit idle. A query beat sweeps every complete
//   entry (none with an empty gallery): the shared multiply-accumulate
//   unit visits one entry per cycle, plus the memory read and pipeline
//   drain. The last element adds a report step that hands the result to
//   the output register.
//   in_stall is high while a beat is in progress.
//   Reset empties the gallery and restores the register defaults; no
//   memory clearing is needed. A stalled result sits in the output
//   register; a further query that finishes meanwhile waits for it.
module nearest_match_by_dot_product_unit #(
  parameter int MAX_ENTRIES = nmdp_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = nmdp_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nmdp_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nmdp_pkg::out_beat_t               out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [nmdp_pkg::PADDR_W-1:0]      cfg_paddr,
  input  logic [nmdp_pkg::PDATA_W-1:0]      cfg_pwdata,
  output logic [nmdp_pkg::PDATA_W-1:0]      cfg_prdata,
  output logic                              cfg_pready
);

  import nmdp_pkg::*;

  `include "nearest_match_by_dot_product_unit_assert.svh"

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIMC_W = $clog2(MAX_DIM + 1);
  localparam int GAL_D  = MAX_ENTRIES * MAX_DIM;
  localparam int GAL_AW = (GAL_D > 1) ? $clog2(GAL_D) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [THR_W-1:0] thr_r;
  logic [DIM_W-1:0]        dim_r;
  logic [CNT_W-1:0]        entry_cnt_r, entry_cnt_nxt;
  logic [POS_W-1:0]        load_pos_r, load_pos_nxt;
  logic [GAL_AW-1:0]       load_base_r, load_base_nxt;
  logic [POS_W-1:0]        qpos_r, qpos_nxt;
  logic [CNT_W-1:0]        started_r, started_nxt;
  logic [CNT_W-1:0]        lim_r, lim_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        e_r, e_nxt;
  logic                    last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [GAL_AW-1:0]       gal_raddr_r, gal_raddr_nxt;
  logic                    vb_r, vb_nxt;
  logic                    keepb_r, keepb_nxt;
  logic [IDX_W-1:0]        eb_r;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_r, out_nxt;

  logic [DIMC_W-1:0]       dim_eff;
  logic                    in_accept;
  logic                    cfg_wr;
  logic                    issue;
  logic                    load_ok;
  logic                    gal_we;
  logic [GAL_AW-1:0]       gal_waddr;
  logic signed [SAMPLE_W-1:0] gal_rdata;
  logic signed [ACC_W-1:0] acc_rdata;
  logic                    acc_we;
  logic [IDX_W-1:0]        acc_waddr;
  logic signed [ACC_W-1:0] acc_wdata;
  logic signed [ACC_W-1:0] best_val;
  logic [IDX_W-1:0]        best_idx;
  sweep_ctl_t              mac_ctl;
  mac_stat_t               mac_stat;
  logic                    out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_DIM) ? PDATA_W'(dim_r) : PDATA_W'(thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      dim_r <= DIM_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_THRESHOLD) begin
        thr_r <= cfg_pwdata[THR_W-1:0];
      end else begin
        dim_r <= cfg_pwdata[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (dim_r == '0) begin
      dim_eff = DIMC_W'(1);
    end else if (32'(dim_r) > 32'(MAX_DIM)) begin
      dim_eff = DIMC_W'(MAX_DIM);
    end else begin
      dim_eff = DIMC_W'(dim_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & !in_stall;
  assign load_ok   = (entry_cnt_r < CNT_W'(MAX_ENTRIES));
  assign gal_we    = in_accept && (in_data.op == OP_LOAD) && load_ok;
  assign gal_waddr = load_base_r + GAL_AW'(load_pos_r);
  assign issue     = (state_r == S_SWEEP) && (e_r != n_r);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    entry_cnt_nxt = entry_cnt_r;
    load_pos_nxt  = load_pos_r;
    load_base_nxt = load_base_r;
    qpos_nxt      = qpos_r;
    started_nxt   = started_r;
    lim_nxt       = lim_r;
    n_nxt         = n_r;
    e_nxt         = e_r;
    last_nxt      = last_r;
    sample_nxt    = sample_r;
    gal_raddr_nxt = gal_raddr_r;
    vb_nxt        = issue;
    keepb_nxt     = (e_r < lim_r);
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mac_ctl.clear    = 1'b0;
    mac_ctl.valid    = vb_r;
    mac_ctl.keep_old = keepb_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_data.op == OP_LOAD)) begin
          if (load_ok) begin
            if ((DIMC_W'(load_pos_r) + DIMC_W'(1)) >= dim_eff) begin
              entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
              load_pos_nxt  = '0;
              load_base_nxt = load_base_r + GAL_AW'(MAX_DIM);
            end else begin
              load_pos_nxt  = load_pos_r + POS_W'(1);
            end
          end
        end else if (in_accept) begin
          last_nxt      = (DIMC_W'(qpos_r) + DIMC_W'(1)) >= dim_eff;
          qpos_nxt      = last_nxt ? '0 : (qpos_r + POS_W'(1));
          lim_nxt       = (qpos_r == '0) ? '0 : started_r;
          started_nxt   = entry_cnt_r;
          n_nxt         = entry_cnt_r;
          e_nxt         = '0;
          sample_nxt    = in_data.sample_value;
          gal_raddr_nxt = GAL_AW'(qpos_r);
          mac_ctl.clear = 1'b1;
          state_nxt     = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (issue) begin
          e_nxt         = e_r + CNT_W'(1);
          gal_raddr_nxt = gal_raddr_r + GAL_AW'(MAX_DIM);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!vb_r && !mac_stat.busy) begin
          state_nxt = last_r ? S_REPORT : S_IDLE;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.best_entry = ENTRY_W'(best_idx);
          out_nxt.similarity = mac_stat.found ? best_val : '0;
          out_nxt.known      = mac_stat.found && (best_val >= ACC_W'(thr_r));
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entry_cnt_r <= '0;
      load_pos_r  <= '0;
      load_base_r <= '0;
      qpos_r      <= '0;
      started_r   <= '0;
      lim_r       <= '0;
      n_r         <= '0;
      e_r         <= '0;
      last_r      <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      load_pos_r  <= load_pos_nxt;
      load_base_r <= load_base_nxt;
      qpos_r      <= qpos_nxt;
      started_r   <= started_nxt;
      lim_r       <= lim_nxt;
      n_r         <= n_nxt;
      e_r         <= e_nxt;
      last_r      <= last_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    gal_raddr_r <= gal_raddr_nxt;
    keepb_r     <= keepb_nxt;
    eb_r        <= e_r[IDX_W-1:0];
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  nmdp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (GAL_D)
  ) u_gallery (
    .clk   (clk),
    .we    (gal_we),
    .waddr (gal_waddr),
    .wdata (in_data.sample_value),
    .raddr (gal_raddr_r),
    .rdata (gal_rdata)
  );

  nmdp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (e_r[IDX_W-1:0]),
    .rdata (acc_rdata)
  );

  nmdp_mac #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .idx       (eb_r),
    .sample    (sample_r),
    .gal_data  (gal_rdata),
    .acc_data  (acc_rdata),
    .acc_we    (acc_we),
    .acc_waddr (acc_waddr),
    .acc_wdata (acc_wdata),
    .best_val  (best_val),
    .best_idx  (best_idx),
    .stat      (mac_stat)
  );

  `NMDP_ASSERT(a_cnt_bound, entry_cnt_r <= CNT_W'(MAX_ENTRIES), "entry count past gallery size")
  `NMDP_ASSERT(a_sweep_bound, (state_r == S_SWEEP) |-> (e_r <= n_r), "sweep past entry count")
  `NMDP_ASSERT(a_idle_drained, (state_r == S_IDLE) |-> (!vb_r && !mac_stat.busy), "busy in idle")
  `NMDP_ASSERT_NEXT(a_report_out, (state_r == S_REPORT) && out_free, out_valid_r && (state_r == S_IDLE), "result not delivered")

endmodule

/* tb/nearest_match_by_dot_product_unit_tb.sv */
// Self-checking testbench: gallery loads and queries against an in-bench match predictor
`timescale 1ns / 100ps

module nearest_match_by_dot_product_unit_tb;
  import nmdp_pkg::*;

  localparam int ENTRIES       = MAX_ENTRIES_DEF;
  localparam int DIM_MAX       = MAX_DIM_DEF;
  localparam int SETTLE_CYCLES = MAX_ENTRIES_DEF + 16;

  typedef struct {
    bit          is_cfg;
    logic        reg_sel;
    logic [31:0] reg_val;
    in_beat_t    beat;
    bit          typed;
    out_beat_t   result;
  } script_row_t;

  typedef struct {
    logic [8:0]  dim;
    logic [31:0] thr;
    bit          thr_rand;
    int          n_beats;
    int          load_pct;
    int          send_pct;
    int          stall_pct;
  } phase_t;

  localparam out_beat_t NO_MATCH = '0;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_beat_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_beat_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr  = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic signed [SAMPLE_W-1:0] gallery_copy [ENTRIES][DIM_MAX];
  logic signed [ACC_W-1:0]    dot_acc [ENTRIES];
  int                         entry_cnt  = 0;
  int                         load_pos   = 0;
  int                         query_pos  = 0;
  int                         wlen_min   = DIM_MAX;
  logic signed [THR_W-1:0]    thr_copy   = THR_RESET;
  logic [DIM_W-1:0]           dim_copy   = DIM_RESET;

  out_beat_t pending_matches [$];
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;

  script_row_t dir_script [12] = '{
    '{1, REG_DIM,       32'd1,         '0,                    0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_QUERY, 16'h7FFF},  1, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_QUERY, 16'h8000},  1, NO_MATCH},
    '{1, REG_THRESHOLD, 32'hC000_0000, '0,                    0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_QUERY, 16'h0000},  1, NO_MATCH},
    '{1, REG_DIM,       32'd0,         '0,                    0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_QUERY, 16'h0001},  1, NO_MATCH},
    '{1, REG_THRESHOLD, 32'h4000_0000, '0,                    0, NO_MATCH},
    '{1, REG_DIM,       32'd511,       '0,                    0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_LOAD, 16'h7FFF},   0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_LOAD, 16'h8000},   0, NO_MATCH},
    '{0, REG_DIM,       '0,            {OP_QUERY, 16'hFFFF},  0, NO_MATCH}
  };

  // dims only shrink once entries exist, so no query reads an unwritten element
  phase_t phases [8] = '{
    '{9'd256, 32'h2000_0000, 0, 450, 50,  0,  0},
    '{9'd40,  32'hC000_0000, 0, 120, 50, 78,  0},
    '{9'd9,   32'h4000_0000, 0, 120, 40,  0, 78},
    '{9'd3,   32'h0,         1, 100, 40, 18, 18},
    '{9'd2,   32'h0,         0,  90, 45,  0,  0},
    '{9'd1,   32'h0,         1, 120, 40, 78,  0},
    '{9'd0,   32'h0,         1,  90, 30,  0, 78},
    '{9'd1,   32'h0,         1,  60, 30, 18, 18}
  };

  nearest_match_by_dot_product_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("[nearest_match_by_dot_product_unit] ERROR");
    $finish;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return int'(raw);
  endfunction

  // a load that completes an entry must cover the query position still open
  function automatic bit load_safe();
    if (entry_cnt >= ENTRIES || load_pos + 1 < eff_dim(dim_copy)) return 1'b1;
    return load_pos + 1 > query_pos;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void predict_match(input in_beat_t beat, output bit produced,
                                        output out_beat_t res);
    int                      d;
    int                      best;
    longint                  sum;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [ACC_W-1:0] best_val;
    d        = eff_dim(dim_copy);
    smp      = beat.sample_value;
    produced = 1'b0;
    res      = NO_MATCH;
    if (beat.op == OP_LOAD) begin
      if (entry_cnt < ENTRIES) begin
        if (load_pos < DIM_MAX) gallery_copy[entry_cnt][load_pos] = smp;
        load_pos++;
        if (load_pos >= d) begin
          if (entry_cnt == 0 || load_pos < wlen_min) wlen_min = load_pos;
          entry_cnt++;
          load_pos = 0;
        end
      end
      return;
    end
    if (query_pos < DIM_MAX) begin
      for (int e = 0; e < entry_cnt; e++) begin
        sum = longint'(dot_acc[e])
            + longint'(gallery_copy[e][query_pos]) * longint'(smp);
        if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
        if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
        dot_acc[e] = sum[ACC_W-1:0];
      end
    end
    query_pos++;
    if (query_pos < d) return;
    query_pos = 0;
    best      = 0;
    best_val  = '0;
    if (entry_cnt > 0) begin
      best_val = dot_acc[0];
      for (int e = 1; e < entry_cnt; e++) begin
        if (dot_acc[e] > best_val) begin
          best_val = dot_acc[e];
          best     = e;
        end
      end
      res.known = (best_val >= thr_copy);
    end
    res.best_entry = best[ENTRY_W-1:0];
    res.similarity = best_val;
    for (int e = 0; e < ENTRIES; e++) dot_acc[e] = '0;
    produced = 1'b1;
  endfunction

  task automatic push_sample(input in_beat_t beat, input bit typed, input out_beat_t typed_res);
    bit        produced;
    out_beat_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_match(beat, produced, res);
    if (produced) pending_matches.insert(pending_matches.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic drain_matches();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic read_reg_check(input logic sel);
    logic [31:0] want;
    logic [31:0] got;
    want = (sel == REG_THRESHOLD) ? thr_copy : {{(32-DIM_W){1'b0}}, dim_copy};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {sel, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d readback: expected %h, got %h", sel, want, got);
    end
    @(negedge clk);
  endtask

  task automatic program_reg(input logic sel, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (sel == REG_THRESHOLD) thr_copy = val;
    else dim_copy = val[DIM_W-1:0];
    @(negedge clk);
    read_reg_check(sel);
  endtask

  task automatic run_phase(input phase_t ph);
    int         sent;
    int         burst;
    int         pos;
    int         d;
    logic       op;
    logic       op_now;
    logic [8:0] dim_val;
    logic [31:0] thr_val;
    drain_matches();
    send_idle_pct = ph.send_pct;
    stall_pct     = ph.stall_pct;
    thr_val = ph.thr_rand ? $urandom_range(32'h8000_0000, 0) - 32'h4000_0000 : ph.thr;
    dim_val = ph.dim;
    if (entry_cnt > 0 && eff_dim(dim_val) > wlen_min) dim_val = 9'(wlen_min);
    program_reg(REG_THRESHOLD, thr_val);
    program_reg(REG_DIM, {23'd0, dim_val});
    sent = 0;
    while (sent < ph.n_beats) begin
      op  = (entry_cnt == 0 || $urandom_range(99) < ph.load_pct) ? OP_LOAD : OP_QUERY;
      d   = eff_dim(dim_copy);
      pos = (op == OP_LOAD) ? load_pos : query_pos;
      // mostly whole vectors, now and then a broken one
      if ($urandom_range(99) < 85) burst = (pos < d) ? d - pos : 1;
      else burst = $urandom_range(d, 1);
      for (int k = 0; k < burst && sent < ph.n_beats; k++) begin
        op_now = (op == OP_LOAD && !load_safe()) ? OP_QUERY : op;
        sent++;
        push_sample({op_now, pick_sample()}, 1'b0, NO_MATCH);
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: entry %0d sim %0d known %0b",
                   out_data.best_entry, out_data.similarity, out_data.known);
      end else begin
        want = pending_matches.pop_front();
        if (out_data.best_entry !== want.best_entry || out_data.similarity !== want.similarity
            || out_data.known !== want.known) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected entry %0d sim %0d known %0b, got %0d %0d %0b",
                     want.best_entry, want.similarity, want.known,
                     out_data.best_entry, out_data.similarity, out_data.known);
        end
      end
    end
  end

  initial begin
    for (int e = 0; e < ENTRIES; e++) dot_acc[e] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_reg_check(REG_THRESHOLD);
    read_reg_check(REG_DIM);
    foreach (dir_script[i]) begin
      if (dir_script[i].is_cfg) begin
        drain_matches();
        program_reg(dir_script[i].reg_sel, dir_script[i].reg_val);
      end else begin
        push_sample(dir_script[i].beat, dir_script[i].typed, dir_script[i].result);
      end
    end
    foreach (phases[i]) run_phase(phases[i]);
    drain_matches();
    if (mismatches == 0) begin
      $display("[nearest_match_by_dot_product_unit] OK");
    end else begin
      $display("[nearest_match_by_dot_product_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/nmdp_pkg.sv
rtl/nmdp_ram.sv
rtl/nmdp_mac.sv
rtl/nearest_match_by_dot_product_unit.sv
tb/nearest_match_by_dot_product_unit_tb.sv
